[sv/gf2_13_arith_unit_assert.svh]
// Assertion macros for the GF(2^13) arithmetic unit.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef GF2_13_ARITH_UNIT_ASSERT_SVH
`define GF2_13_ARITH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define GF13_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gf13 same-cycle check failed");
`define GF13_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gf13 next-cycle check failed");
`else
`define GF13_ASSERT_SAME(label, ante, cons)
`define GF13_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[sv/gf13_pkg.sv]
// Shared types, constants and GF(2^13) field functions for the arithmetic unit.
// No dependencies; used by every module of the block.
package gf13_pkg;

    localparam int NUM_LANES = 4;
    localparam int GF_BITS   = 13;

    typedef logic [GF_BITS-1:0] gf_elem_t;

    typedef enum logic [1:0] {
        CMD_MUL = 2'd0,
        CMD_SQR = 2'd1,
        CMD_INV = 2'd2,
        CMD_MAC = 2'd3
    } cmd_e;

    typedef struct packed {
        logic [1:0] command;
        logic       first;
        gf_elem_t   a_lane0;
        gf_elem_t   a_lane1;
        gf_elem_t   a_lane2;
        gf_elem_t   a_lane3;
        gf_elem_t   b_lane0;
        gf_elem_t   b_lane1;
        gf_elem_t   b_lane2;
        gf_elem_t   b_lane3;
    } req_item_t;

    typedef struct packed {
        gf_elem_t r_lane0;
        gf_elem_t r_lane1;
        gf_elem_t r_lane2;
        gf_elem_t r_lane3;
    } res_item_t;

    typedef struct packed {
        logic       load;
        logic       advance;
        logic       finish;
        logic [1:0] step;
        cmd_e       cmd;
        logic       first;
    } lane_ctrl_t;

    // Fold a 25-bit carry-less product with x^13 = x^4 + x^3 + x + 1.
    function automatic gf_elem_t gf_reduce(input logic [24:0] p);
        logic [11:0] h;
        logic [15:0] r1;
        logic [2:0]  g;
        h  = p[24:13];
        r1 = {3'b0, p[12:0]} ^ {4'b0, h} ^ {3'b0, h, 1'b0}
           ^ {1'b0, h, 3'b0} ^ {h, 4'b0};
        g  = r1[15:13];
        return r1[12:0] ^ {10'b0, g} ^ {9'b0, g, 1'b0}
             ^ {7'b0, g, 3'b0} ^ {6'b0, g, 4'b0};
    endfunction

    function automatic gf_elem_t gf_mul(input gf_elem_t x, input gf_elem_t y);
        logic [24:0] p;
        p = '0;
        for (int i = 0; i < GF_BITS; i++) begin
            if (y[i]) begin
                p = p ^ ({12'b0, x} << i);
            end
        end
        return gf_reduce(p);
    endfunction

    function automatic gf_elem_t gf_sq(input gf_elem_t x);
        logic [24:0] p;
        p = '0;
        for (int i = 0; i < GF_BITS; i++) begin
            p[2*i] = x[i];
        end
        return gf_reduce(p);
    endfunction

endpackage

[sv/gf13_lane.sv]
// One GF(2^13) lane: operand registers, square-chain-and-multiply step, accumulator.
// Depends on gf13_pkg; driven by gf13_ctrl through lane_ctrl_t.
module gf13_lane
    import gf13_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lane_ctrl_t ctl,
    input  gf_elem_t   a,
    input  gf_elem_t   b,
    output gf_elem_t   res
);

    gf_elem_t t_reg, t_next;
    gf_elem_t b_reg, b_next;
    gf_elem_t acc_reg, acc_next;
    gf_elem_t sq1, sq2, sq4, xs, y, prod, acc_sum;

    always_comb
    begin
        sq1 = gf_sq(t_reg);
        sq2 = gf_sq(sq1);
        sq4 = gf_sq(gf_sq(sq2));
        case (ctl.step)
            2'd0:
            begin
                xs = (ctl.cmd == CMD_INV) ? sq1 : t_reg;
                y  = (ctl.cmd == CMD_MUL || ctl.cmd == CMD_MAC) ? b_reg : t_reg;
            end
            2'd1:
            begin
                xs = sq2;
                y  = t_reg;
            end
            2'd2:
            begin
                xs = sq4;
                y  = t_reg;
            end
            default:
            begin
                xs = sq4;
                y  = b_reg;
            end
        endcase
        prod    = gf_mul(xs, y);
        acc_sum = (ctl.first ? '0 : acc_reg) ^ prod;
        case (ctl.cmd)
            CMD_MAC: res = acc_sum;
            CMD_INV: res = gf_sq(prod);
            default: res = prod;
        endcase
    end

    always_comb
    begin
        t_next   = t_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        if (ctl.load)
        begin
            t_next = a;
            b_next = b;
        end
        else if (ctl.advance)
        begin
            t_next = prod;
            if (ctl.step == 2'd1)
            begin
                b_next = prod;
            end
        end
        if (ctl.finish && ctl.cmd == CMD_MAC)
        begin
            acc_next = acc_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        b_reg <= b_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

[sv/gf13_ctrl.sv]
// Shared sequencer for the lanes: handshakes, step count, result valid.
// Depends on gf13_pkg and the assertion macros header.
`include "gf2_13_arith_unit_assert.svh"
module gf13_ctrl
    import gf13_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  logic [1:0] command,
    input  logic       first,
    output logic       res_valid,
    input  logic       res_ready,
    output lane_ctrl_t ctl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CALC = 2'b10
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] step_reg, step_next;
    cmd_e       cmd_reg, cmd_next;
    logic       first_reg, first_next;
    logic       valid_reg, valid_next;
    logic       load, last, finish, advance;

    always_comb
    begin
        cmd_ready = (state_reg == ST_IDLE);
        load      = cmd_valid && cmd_ready;
        last      = (cmd_reg == CMD_INV) ? (step_reg == 2'd3) : 1'b1;
        finish    = (state_reg == ST_CALC) && last && (!valid_reg || res_ready);
        advance   = (state_reg == ST_CALC) && !last;

        state_next = state_reg;
        step_next  = step_reg;
        cmd_next   = cmd_reg;
        first_next = first_reg;
        valid_next = valid_reg;
        if (res_ready)
        begin
            valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    state_next = ST_CALC;
                    step_next  = 2'd0;
                    cmd_next   = cmd_e'(command);
                    first_next = first;
                end
            end
            ST_CALC:
            begin
                if (advance)
                begin
                    step_next = step_reg + 2'd1;
                end
                if (finish)
                begin
                    state_next = ST_IDLE;
                    valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 2'd0;
            cmd_reg   <= CMD_MUL;
            first_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cmd_reg   <= cmd_next;
            first_reg <= first_next;
            valid_reg <= valid_next;
        end
    end

    assign res_valid   = valid_reg;
    assign ctl.load    = load;
    assign ctl.advance = advance;
    assign ctl.finish  = finish;
    assign ctl.step    = step_reg;
    assign ctl.cmd     = cmd_reg;
    assign ctl.first   = first_reg;

    `GF13_ASSERT_NEXT(a_finish_sets_valid, finish, valid_reg)
    `GF13_ASSERT_NEXT(a_load_starts_calc, load, state_reg == ST_CALC && step_reg == 2'd0)
    `GF13_ASSERT_SAME(a_single_step_cmd, state_reg == ST_CALC && cmd_reg != CMD_INV, step_reg == 2'd0)

endmodule

[sv/gf2_13_arith_unit.sv]
// GF(2^13) arithmetic unit: four lanes, field polynomial x^13+x^4+x^3+x+1.
// Depends on gf13_pkg, gf13_ctrl and gf13_lane.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd_data) takes one item: a command
//   (multiply, square, invert, multiply-accumulate), a first flag and per
//   lane operands a and b. res channel (res_valid/res_ready/res_data) returns
//   one item per command with one 13-bit element per lane.
//   Multiply, square and multiply-accumulate take one step of the lane
//   square-and-multiply unit; invert takes four steps of it (a^3, a^15,
//   a^255, a^4095, then a final square). A result and res_valid are registered
//   as its last step completes. A new item is accepted only after the
//   previous one has finished its steps.
//   The result register is separate from the lanes, so the next item is
//   taken while an earlier result still waits. If the receiver stalls, the
//   following item finishes its steps and then holds until the result
//   register frees up.
//   Reset clears the accumulators to zero and returns the unit to idle.
module gf2_13_arith_unit
    import gf13_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  req_item_t cmd_data,
    output logic      res_valid,
    input  logic      res_ready,
    output res_item_t res_data
);

    lane_ctrl_t ctl;
    gf_elem_t   a_arr    [NUM_LANES];
    gf_elem_t   b_arr    [NUM_LANES];
    gf_elem_t   lane_res [NUM_LANES];
    res_item_t  res_reg, res_next;

    assign a_arr[0] = cmd_data.a_lane0;
    assign a_arr[1] = cmd_data.a_lane1;
    assign a_arr[2] = cmd_data.a_lane2;
    assign a_arr[3] = cmd_data.a_lane3;
    assign b_arr[0] = cmd_data.b_lane0;
    assign b_arr[1] = cmd_data.b_lane1;
    assign b_arr[2] = cmd_data.b_lane2;
    assign b_arr[3] = cmd_data.b_lane3;

    gf13_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .command   (cmd_data.command),
        .first     (cmd_data.first),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .ctl       (ctl)
    );

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        gf13_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .a     (a_arr[i]),
            .b     (b_arr[i]),
            .res   (lane_res[i])
        );
    end

    always_comb
    begin
        res_next = res_reg;
        if (ctl.finish)
        begin
            res_next.r_lane0 = lane_res[0];
            res_next.r_lane1 = lane_res[1];
            res_next.r_lane2 = lane_res[2];
            res_next.r_lane3 = lane_res[3];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_data = res_reg;

endmodule
